[rtl/core/gcbp_pkg.sv]
// ---------------------------------------------------------------------------
// GIF container parser package
// Field codes, error kinds, block bytes and the result record.
// ---------------------------------------------------------------------------
package gcbp_pkg;

    localparam int CodeW  = 6;
    localparam int ValueW = 24;
    localparam int FrameW = 16;
    localparam int KindW  = 4;
    localparam int MaxRes = 6;
    localparam int CntW   = 3;

    localparam logic [15:0] MinWidthReset  = 16'd128;
    localparam logic [15:0] MinHeightReset = 16'd64;

    localparam logic [1:0] RegMinWidth  = 2'd0;
    localparam logic [1:0] RegMinHeight = 2'd1;

    localparam logic [7:0] ImageSep   = 8'h2c;
    localparam logic [7:0] ExtIntro   = 8'h21;
    localparam logic [7:0] GceLabel   = 8'hf9;
    localparam logic [7:0] CommentLbl = 8'hfe;
    localparam logic [7:0] AppLabel   = 8'hff;
    localparam logic [7:0] TrailerB   = 8'h3b;
    localparam logic [7:0] PlainLabel = 8'h01;
    localparam logic [7:0] NullByte   = 8'h00;
    localparam logic [7:0] AppSubSize = 8'h03;

    localparam logic [CodeW-1:0] FcVersion    = 6'd0;
    localparam logic [CodeW-1:0] FcWidth      = 6'd1;
    localparam logic [CodeW-1:0] FcHeight     = 6'd2;
    localparam logic [CodeW-1:0] FcGctFlag    = 6'd3;
    localparam logic [CodeW-1:0] FcColorRes   = 6'd4;
    localparam logic [CodeW-1:0] FcSortFlag   = 6'd5;
    localparam logic [CodeW-1:0] FcGctEntries = 6'd6;
    localparam logic [CodeW-1:0] FcBgIndex    = 6'd7;
    localparam logic [CodeW-1:0] FcAspect     = 6'd8;
    localparam logic [CodeW-1:0] FcGctColor   = 6'd9;
    localparam logic [CodeW-1:0] FcGceSize    = 6'd10;
    localparam logic [CodeW-1:0] FcGceRsvd    = 6'd11;
    localparam logic [CodeW-1:0] FcDisposal   = 6'd12;
    localparam logic [CodeW-1:0] FcUserInput  = 6'd13;
    localparam logic [CodeW-1:0] FcTranspFlag = 6'd14;
    localparam logic [CodeW-1:0] FcDelay      = 6'd15;
    localparam logic [CodeW-1:0] FcTranspIdx  = 6'd16;
    localparam logic [CodeW-1:0] FcAppByte    = 6'd17;
    localparam logic [CodeW-1:0] FcAppWord    = 6'd18;
    localparam logic [CodeW-1:0] FcImgLeft    = 6'd19;
    localparam logic [CodeW-1:0] FcLctFlag    = 6'd23;
    localparam logic [CodeW-1:0] FcInterlace  = 6'd24;
    localparam logic [CodeW-1:0] FcImgSort    = 6'd25;
    localparam logic [CodeW-1:0] FcImgRsvd    = 6'd26;
    localparam logic [CodeW-1:0] FcLctEntries = 6'd27;
    localparam logic [CodeW-1:0] FcLctColor   = 6'd28;
    localparam logic [CodeW-1:0] FcLzwSize    = 6'd29;
    localparam logic [CodeW-1:0] FcTrailer    = 6'd30;
    localparam logic [CodeW-1:0] FcError      = 6'd31;
    localparam logic [CodeW-1:0] FcCleanEnd   = 6'd32;

    localparam logic [KindW-1:0] ErrNone      = 4'd0;
    localparam logic [KindW-1:0] ErrSignature = 4'd1;
    localparam logic [KindW-1:0] ErrWidth     = 4'd2;
    localparam logic [KindW-1:0] ErrHeight    = 4'd3;
    localparam logic [KindW-1:0] ErrBlockType = 4'd4;
    localparam logic [KindW-1:0] ErrExtLabel  = 4'd5;
    localparam logic [KindW-1:0] ErrComment   = 4'd6;
    localparam logic [KindW-1:0] ErrPlainText = 4'd7;
    localparam logic [KindW-1:0] ErrAppSize   = 4'd8;
    localparam logic [KindW-1:0] ErrGceTerm   = 4'd9;
    localparam logic [KindW-1:0] ErrAppTerm   = 4'd10;
    localparam logic [KindW-1:0] ErrNoTrailer = 4'd11;
    localparam logic [KindW-1:0] ErrTruncated = 4'd12;

    typedef struct packed {
        logic [CodeW-1:0]  code;
        logic [ValueW-1:0] value;
        logic [KindW-1:0]  kind;
    } result_t;

    // Expected signature byte at a header position.
    function automatic logic [7:0] sig_byte(input logic [1:0] pos);
        logic [7:0] r;
        case (pos)
            2'd0:    r = 8'h47;
            2'd1:    r = 8'h49;
            default: r = 8'h46;
        endcase
        return r;
    endfunction

    // Places a byte in one of the three little-endian byte lanes.
    function automatic logic [ValueW-1:0] lane(input logic [7:0] b, input logic [1:0] sel);
        logic [ValueW-1:0] r;
        case (sel)
            2'd0:    r = {16'd0, b};
            2'd1:    r = {8'd0, b, 8'd0};
            default: r = {b, 16'd0};
        endcase
        return r;
    endfunction

endpackage

[rtl/core/gif_container_byte_parser.sv]
// Results: the results of an item are registered and appear in the cycle after
// it is accepted. Throughput: one item per cycle while each item gives at most
// one result and the result side is ready; an item that gives more results
// (up to 6) holds the input until the per-item result bundle register drains.
// Reset: asynchronous, active low; parser returns to the signature check
// and the screen size limits return to 128 by 64.
// ---------------------------------------------------------------------------
// GIF container byte parser
// Walks the GIF block structure one byte per item and reports decoded
// fields, the trailer, a clean end or an error.
// ---------------------------------------------------------------------------
module gif_container_byte_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [5:0] field_code, [29:6] field_value,
                                   // [45:30] frame_number, [49:46] error_kind, zeros
    output logic        m_tlast,   // last_in_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [3:0] {
        PH_HDR, PH_GCT, PH_BLOCK, PH_LABEL, PH_GCE, PH_APP, PH_IMG,
        PH_LCT, PH_LZW, PH_SUBLEN, PH_SUBDATA, PH_ERROR, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [9:0]  sec_reg, sec_next;
    logic [1:0]  tri_reg, tri_next;
    logic [23:0] va_reg, va_next;
    logic        mism_reg, mism_next;
    logic        gtp_reg, gtp_next;
    logic [8:0]  gte_reg, gte_next;
    logic        ltp_reg, ltp_next;
    logic [8:0]  lte_reg, lte_next;
    logic [7:0]  sub_reg, sub_next;
    logic        trl_reg, trl_next;
    logic [15:0] frm_reg, frm_next;
    logic        fhc_reg, fhc_next;
    logic        fhi_reg, fhi_next;
    logic [15:0] minw_reg, minh_reg;

    gcbp_pkg::result_t res_next [gcbp_pkg::MaxRes];
    gcbp_pkg::result_t bun_reg  [gcbp_pkg::MaxRes];
    logic [gcbp_pkg::CntW-1:0] n_next, cnt_reg, idx_reg;
    logic [15:0] bfrm_reg;

    logic        in_acc, out_acc;
    logic [7:0]  b;
    logic [9:0]  p;
    logic [9:0]  total;
    logic [8:0]  ents;
    logic        err;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign b         = s_tdata;
    assign p         = sec_reg;
    assign ents      = (phase_reg == PH_GCT) ? gte_reg : lte_reg;
    assign total     = {1'b0, ents} + {ents, 1'b0};

    always_comb
    begin
        phase_next = phase_reg;
        sec_next   = p + 10'd1;
        va_next    = va_reg;
        mism_next  = mism_reg;
        gtp_next   = gtp_reg;
        gte_next   = gte_reg;
        ltp_next   = ltp_reg;
        lte_next   = lte_reg;
        sub_next   = sub_reg;
        trl_next   = trl_reg;
        frm_next   = frm_reg;
        fhc_next   = fhc_reg;
        fhi_next   = fhi_reg;
        n_next     = '0;
        err        = 1'b0;
        for (int i = 0; i < gcbp_pkg::MaxRes; i++)
        begin
            res_next[i] = '0;
        end

        case (phase_reg)
            PH_HDR:
            begin
                if (p < 10'd3)
                begin
                    if (b != gcbp_pkg::sig_byte(p[1:0]))
                        mism_next = 1'b1;
                    if (p == 10'd2 && mism_next)
                    begin
                        res_next[n_next] = '{gcbp_pkg::FcError, 24'd0, gcbp_pkg::ErrSignature};
                        n_next = n_next + 3'd1;
                        err = 1'b1;
                    end
                end
                else if (p < 10'd6)
                begin
                    va_next = va_reg | gcbp_pkg::lane(b, 2'(p - 10'd3));
                    if (p == 10'd5)
                    begin
                        res_next[n_next] = '{gcbp_pkg::FcVersion, va_next, gcbp_pkg::ErrNone};
                        n_next = n_next + 3'd1;
                        va_next = '0;
                    end
                end
                else if (p < 10'd8)
                begin
                    va_next = va_reg | gcbp_pkg::lane(b, 2'(p - 10'd6));
                    if (p == 10'd7)
                    begin
                        res_next[n_next] = '{gcbp_pkg::FcWidth, va_next, gcbp_pkg::ErrNone};
                        n_next = n_next + 3'd1;
                        if (va_next[15:0] < minw_reg)
                        begin
                            res_next[n_next] = '{gcbp_pkg::FcError, 24'd0, gcbp_pkg::ErrWidth};
                            n_next = n_next + 3'd1;
                            err = 1'b1;
                        end
                        va_next = '0;
                    end
                end
                else if (p < 10'd10)
                begin
                    va_next = va_reg | gcbp_pkg::lane(b, 2'(p - 10'd8));
                    if (p == 10'd9)
                    begin
                        res_next[n_next] = '{gcbp_pkg::FcHeight, va_next, gcbp_pkg::ErrNone};
                        n_next = n_next + 3'd1;
                        if (va_next[15:0] < minh_reg)
                        begin
                            res_next[n_next] = '{gcbp_pkg::FcError, 24'd0, gcbp_pkg::ErrHeight};
                            n_next = n_next + 3'd1;
                            err = 1'b1;
                        end
                        va_next = '0;
                    end
                end
                else if (p == 10'd10)
                begin
                    gtp_next = b[7];
                    gte_next = 9'd2 << b[2:0];
                    res_next[0] = '{gcbp_pkg::FcGctFlag, {23'd0, b[7]}, gcbp_pkg::ErrNone};
                    res_next[1] = '{gcbp_pkg::FcColorRes, {20'd0, {1'b0, b[6:4]} + 4'd1},
                                    gcbp_pkg::ErrNone};
                    res_next[2] = '{gcbp_pkg::FcSortFlag, {23'd0, b[3]}, gcbp_pkg::ErrNone};
                    res_next[3] = '{gcbp_pkg::FcGctEntries, {15'd0, gte_next}, gcbp_pkg::ErrNone};
                    n_next = 3'd4;
                end
                else if (p == 10'd11)
                begin
                    res_next[0] = '{gcbp_pkg::FcBgIndex, {16'd0, b}, gcbp_pkg::ErrNone};
                    n_next = 3'd1;
                end
                else
                begin
                    res_next[0] = '{gcbp_pkg::FcAspect, {16'd0, b}, gcbp_pkg::ErrNone};
                    n_next = 3'd1;
                    phase_next = gtp_reg ? PH_GCT : PH_BLOCK;
                    sec_next = '0;
                    va_next = '0;
                end
            end
            PH_GCT, PH_LCT:
            begin
                va_next = {va_reg[15:0], b};
                if (tri_reg == 2'd2)
                begin
                    res_next[0] = '{(phase_reg == PH_GCT) ? gcbp_pkg::FcGctColor
                                                          : gcbp_pkg::FcLctColor,
                                    va_next, gcbp_pkg::ErrNone};
                    n_next = 3'd1;
                    va_next = '0;
                end
                if (p + 10'd1 >= total)
                begin
                    phase_next = (phase_reg == PH_GCT) ? PH_BLOCK : PH_LZW;
                    sec_next = '0;
                    va_next = '0;
                end
            end
            PH_BLOCK:
            begin
                if (b == gcbp_pkg::ImageSep)
                begin
                    if (fhi_reg)
                    begin
                        if (frm_reg != 16'hffff)
                            frm_next = frm_reg + 16'd1;
                        fhc_next = 1'b0;
                    end
                    fhi_next = 1'b1;
                    phase_next = PH_IMG;
                    sec_next = '0;
                    va_next = '0;
                end
                else if (b == gcbp_pkg::ExtIntro)
                begin
                    phase_next = PH_LABEL;
                    sec_next = '0;
                    va_next = '0;
                end
                else if (b == gcbp_pkg::TrailerB)
                begin
                    trl_next = 1'b1;
                    res_next[0] = '{gcbp_pkg::FcTrailer, 24'd0, gcbp_pkg::ErrNone};
                    n_next = 3'd1;
                    sec_next = '0;
                end
                else if (b == gcbp_pkg::NullByte)
                begin
                    sec_next = '0;
                end
                else
                begin
                    res_next[0] = '{gcbp_pkg::FcError, 24'd0, gcbp_pkg::ErrBlockType};
                    n_next = 3'd1;
                    err = 1'b1;
                end
            end
            PH_LABEL:
            begin
                if (b == gcbp_pkg::GceLabel)
                begin
                    if (fhc_reg)
                    begin
                        if (frm_reg != 16'hffff)
                            frm_next = frm_reg + 16'd1;
                        fhi_next = 1'b0;
                    end
                    fhc_next = 1'b1;
                    phase_next = PH_GCE;
                    sec_next = '0;
                    va_next = '0;
                end
                else if (b == gcbp_pkg::AppLabel)
                begin
                    phase_next = PH_APP;
                    sec_next = '0;
                    va_next = '0;
                end
                else
                begin
                    res_next[0] = '{gcbp_pkg::FcError, 24'd0,
                                    (b == gcbp_pkg::CommentLbl) ? gcbp_pkg::ErrComment :
                                    (b == gcbp_pkg::PlainLabel) ? gcbp_pkg::ErrPlainText :
                                                                  gcbp_pkg::ErrExtLabel};
                    n_next = 3'd1;
                    err = 1'b1;
                end
            end
            PH_GCE:
            begin
                if (p == 10'd0)
                begin
                    res_next[0] = '{gcbp_pkg::FcGceSize, {16'd0, b}, gcbp_pkg::ErrNone};
                    n_next = 3'd1;
                end
                else if (p == 10'd1)
                begin
                    res_next[0] = '{gcbp_pkg::FcGceRsvd, {21'd0, b[7:5]}, gcbp_pkg::ErrNone};
                    res_next[1] = '{gcbp_pkg::FcDisposal, {21'd0, b[4:2]}, gcbp_pkg::ErrNone};
                    res_next[2] = '{gcbp_pkg::FcUserInput, {23'd0, b[1]}, gcbp_pkg::ErrNone};
                    res_next[3] = '{gcbp_pkg::FcTranspFlag, {23'd0, b[0]}, gcbp_pkg::ErrNone};
                    n_next = 3'd4;
                end
                else if (p < 10'd4)
                begin
                    va_next = va_reg | gcbp_pkg::lane(b, 2'(p - 10'd2));
                    if (p == 10'd3)
                    begin
                        res_next[0] = '{gcbp_pkg::FcDelay, va_next, gcbp_pkg::ErrNone};
                        n_next = 3'd1;
                        va_next = '0;
                    end
                end
                else if (p == 10'd4)
                begin
                    res_next[0] = '{gcbp_pkg::FcTranspIdx, {16'd0, b}, gcbp_pkg::ErrNone};
                    n_next = 3'd1;
                end
                else if (b != gcbp_pkg::NullByte)
                begin
                    res_next[0] = '{gcbp_pkg::FcError, 24'd0, gcbp_pkg::ErrGceTerm};
                    n_next = 3'd1;
                    err = 1'b1;
                end
                else
                begin
                    phase_next = PH_BLOCK;
                    sec_next = '0;
                    va_next = '0;
                end
            end
            PH_APP:
            begin
                if (p < 10'd12)
                begin
                    // Block size, identifier and authentication bytes are skipped.
                end
                else if (p == 10'd12)
                begin
                    if (b != gcbp_pkg::AppSubSize)
                    begin
                        res_next[0] = '{gcbp_pkg::FcError, 24'd0, gcbp_pkg::ErrAppSize};
                        n_next = 3'd1;
                        err = 1'b1;
                    end
                end
                else if (p == 10'd13)
                begin
                    res_next[0] = '{gcbp_pkg::FcAppByte, {16'd0, b}, gcbp_pkg::ErrNone};
                    n_next = 3'd1;
                end
                else if (p < 10'd16)
                begin
                    va_next = va_reg | gcbp_pkg::lane(b, 2'(p - 10'd14));
                    if (p == 10'd15)
                    begin
                        res_next[0] = '{gcbp_pkg::FcAppWord, va_next, gcbp_pkg::ErrNone};
                        n_next = 3'd1;
                        va_next = '0;
                    end
                end
                else if (b != gcbp_pkg::NullByte)
                begin
                    res_next[0] = '{gcbp_pkg::FcError, 24'd0, gcbp_pkg::ErrAppTerm};
                    n_next = 3'd1;
                    err = 1'b1;
                end
                else
                begin
                    phase_next = PH_BLOCK;
                    sec_next = '0;
                    va_next = '0;
                end
            end
            PH_IMG:
            begin
                if (p < 10'd8)
                begin
                    va_next = va_reg | gcbp_pkg::lane(b, {1'b0, p[0]});
                    if (p[0])
                    begin
                        res_next[0] = '{gcbp_pkg::FcImgLeft + {4'd0, p[2:1]}, va_next,
                                        gcbp_pkg::ErrNone};
                        n_next = 3'd1;
                        va_next = '0;
                    end
                end
                else
                begin
                    ltp_next = b[7];
                    lte_next = 9'd2 << b[2:0];
                    res_next[0] = '{gcbp_pkg::FcLctFlag, {23'd0, b[7]}, gcbp_pkg::ErrNone};
                    res_next[1] = '{gcbp_pkg::FcInterlace, {23'd0, b[6]}, gcbp_pkg::ErrNone};
                    res_next[2] = '{gcbp_pkg::FcImgSort, {23'd0, b[5]}, gcbp_pkg::ErrNone};
                    res_next[3] = '{gcbp_pkg::FcImgRsvd, {22'd0, b[4:3]}, gcbp_pkg::ErrNone};
                    res_next[4] = '{gcbp_pkg::FcLctEntries, {15'd0, lte_next}, gcbp_pkg::ErrNone};
                    n_next = 3'd5;
                    phase_next = b[7] ? PH_LCT : PH_LZW;
                    sec_next = '0;
                    va_next = '0;
                end
            end
            PH_LZW:
            begin
                res_next[0] = '{gcbp_pkg::FcLzwSize, {16'd0, b}, gcbp_pkg::ErrNone};
                n_next = 3'd1;
                phase_next = PH_SUBLEN;
                sec_next = '0;
                va_next = '0;
            end
            PH_SUBLEN:
            begin
                phase_next = (b == gcbp_pkg::NullByte) ? PH_BLOCK : PH_SUBDATA;
                if (b != gcbp_pkg::NullByte)
                    sub_next = b;
                sec_next = '0;
                va_next = '0;
            end
            PH_SUBDATA:
            begin
                sub_next = sub_reg - 8'd1;
                if (sub_next == 8'd0)
                begin
                    phase_next = PH_SUBLEN;
                    sec_next = '0;
                    va_next = '0;
                end
            end
            default:
            begin
                sec_next = sec_reg;
            end
        endcase

        if (err)
            phase_next = PH_ERROR;

        // End of file: clean only at a block boundary after a trailer.
        if (s_tlast && !err && phase_reg != PH_ERROR && phase_reg != PH_DONE)
        begin
            if (phase_next == PH_BLOCK && trl_next)
            begin
                res_next[n_next] = '{gcbp_pkg::FcCleanEnd, 24'd0, gcbp_pkg::ErrNone};
                phase_next = PH_DONE;
            end
            else
            begin
                res_next[n_next] = '{gcbp_pkg::FcError, 24'd0,
                                     (phase_next == PH_BLOCK) ? gcbp_pkg::ErrNoTrailer
                                                              : gcbp_pkg::ErrTruncated};
                phase_next = PH_ERROR;
            end
            n_next = n_next + 3'd1;
        end

        if (phase_reg == PH_ERROR || phase_reg == PH_DONE)
            n_next = '0;

        tri_next = (sec_next == 10'd0) ? 2'd0 : ((tri_reg == 2'd2) ? 2'd0 : tri_reg + 2'd1);
    end

    // A new item is taken once the current bundle is drained or drains now.
    assign s_tready = (idx_reg >= cnt_reg) || ((idx_reg + 3'd1 == cnt_reg) && m_tready);
    assign m_tvalid = idx_reg < cnt_reg;
    assign m_tlast  = (idx_reg + 3'd1 == cnt_reg);
    assign m_tdata  = {6'd0, bun_reg[idx_reg].kind, bfrm_reg,
                       bun_reg[idx_reg].value, bun_reg[idx_reg].code};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            sec_reg   <= '0;
            tri_reg   <= '0;
            va_reg    <= '0;
            mism_reg  <= 1'b0;
            gtp_reg   <= 1'b0;
            gte_reg   <= '0;
            ltp_reg   <= 1'b0;
            lte_reg   <= '0;
            sub_reg   <= '0;
            trl_reg   <= 1'b0;
            frm_reg   <= '0;
            fhc_reg   <= 1'b0;
            fhi_reg   <= 1'b0;
            minw_reg  <= gcbp_pkg::MinWidthReset;
            minh_reg  <= gcbp_pkg::MinHeightReset;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gcbp_pkg::RegMinWidth)
                    minw_reg <= cfg_data;
                else if (cfg_index == gcbp_pkg::RegMinHeight)
                    minh_reg <= cfg_data;
            end
            if (in_acc)
            begin
                phase_reg <= phase_next;
                sec_reg   <= sec_next;
                tri_reg   <= tri_next;
                va_reg    <= va_next;
                mism_reg  <= mism_next;
                gtp_reg   <= gtp_next;
                gte_reg   <= gte_next;
                ltp_reg   <= ltp_next;
                lte_reg   <= lte_next;
                sub_reg   <= sub_next;
                trl_reg   <= trl_next;
                frm_reg   <= frm_next;
                fhc_reg   <= fhc_next;
                fhi_reg   <= fhi_next;
                cnt_reg   <= n_next;
                idx_reg   <= '0;
            end
            else if (out_acc)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            bun_reg  <= res_next;
            bfrm_reg <= frm_next;
        end
    end

    a_bundle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd6)
        else $error("result bundle larger than six");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && m_tvalid) |-> (m_tlast && m_tready))
        else $error("input taken while results remain");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((bun_reg[idx_reg].code == gcbp_pkg::FcError)
                      == (bun_reg[idx_reg].kind != gcbp_pkg::ErrNone)))
        else $error("error kind does not match field code");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (phase_reg == PH_ERROR || phase_reg == PH_DONE)) |=> !m_tvalid)
        else $error("result after parser halted");

endmodule

[tb/gif_container_byte_parser_tb.sv]
// ---------------------------------------------------------------------------
// GIF container byte parser testbench
// Streams one GIF file through the parser, with a directed opening of every
// block kind followed by random well-formed blocks and a randomly chosen
// ending. A scoreboard predicts the decoded fields of each accepted byte and
// checks every result item in order. Both stream sides stall at random.
// ---------------------------------------------------------------------------
module gif_container_byte_parser_tb;

    localparam int          ByteBudget = 380;
    localparam int          StallLimit = 2000;
    localparam logic [1:0]  RegUnused  = 2'd3;
    localparam int          VW         = gcbp_pkg::ValueW;

    typedef enum logic [3:0] {
        PhHeader, PhGlobalTable, PhBlock, PhLabel, PhControl, PhAppExt,
        PhImage, PhLocalTable, PhLzwSize, PhSubLen, PhSubData, PhFailed, PhDone
    } parse_phase_t;

    typedef struct {
        logic [gcbp_pkg::CodeW-1:0]  code;
        logic [gcbp_pkg::ValueW-1:0] value;
        logic [gcbp_pkg::FrameW-1:0] frame;
        logic [gcbp_pkg::KindW-1:0]  kind;
        logic                        last;
    } field_item_t;

    class gif_field_scoreboard;
        logic [15:0]                 min_w = gcbp_pkg::MinWidthReset;
        logic [15:0]                 min_h = gcbp_pkg::MinHeightReset;
        parse_phase_t                phase = PhHeader;
        logic [9:0]                  pos = '0;
        logic [gcbp_pkg::ValueW-1:0] acc = '0;
        logic                        sig_bad = 0, gct_on = 0, lct_on = 0, trailer = 0;
        logic                        has_ctl = 0, has_img = 0;
        int                          gct_n = 0, lct_n = 0;
        logic [7:0]                  sub_left = '0;
        logic [gcbp_pkg::FrameW-1:0] frames = '0;
        field_item_t                 pending[$];
        field_item_t                 batch[$];
        int                          errors = 0;

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == gcbp_pkg::RegMinWidth) min_w = data;
            else if (idx == gcbp_pkg::RegMinHeight) min_h = data;
        endfunction

        function void emit(logic [gcbp_pkg::CodeW-1:0] code,
                           logic [gcbp_pkg::ValueW-1:0] value,
                           logic [gcbp_pkg::KindW-1:0] kind);
            field_item_t f;
            if (batch.size() >= gcbp_pkg::MaxRes) return;
            f.code = code; f.value = value; f.frame = frames; f.kind = kind; f.last = 0;
            batch.push_back(f);
        endfunction

        function void fail(logic [gcbp_pkg::KindW-1:0] kind);
            phase = PhFailed;
            emit(gcbp_pkg::FcError, '0, kind);
        endfunction

        function void enter(parse_phase_t ph);
            phase = ph; pos = '0; acc = '0;
        endfunction

        function void bump_frame();
            if (frames != 16'hffff) frames++;
            has_ctl = 0; has_img = 0;
        endfunction

        function void take(logic [7:0] b);
            logic [9:0]  p;
            logic [7:0]  sig;
            logic        glob;
            int          total;
            p = pos;
            pos = p + 10'd1;
            case (phase)
                PhHeader: begin
                    if (p < 3) begin
                        sig = (p == 0) ? 8'h47 : (p == 1) ? 8'h49 : 8'h46;
                        if (b != sig) sig_bad = 1;
                        if (p == 2 && sig_bad) fail(gcbp_pkg::ErrSignature);
                    end else if (p < 6) begin
                        acc |= VW'(b) << (8 * (p - 3));
                        if (p == 5) begin
                            emit(gcbp_pkg::FcVersion, acc, gcbp_pkg::ErrNone);
                            acc = '0;
                        end
                    end else if (p < 8) begin
                        acc |= VW'(b) << (8 * (p - 6));
                        if (p == 7) begin
                            emit(gcbp_pkg::FcWidth, acc, gcbp_pkg::ErrNone);
                            if (acc < min_w) fail(gcbp_pkg::ErrWidth);
                            acc = '0;
                        end
                    end else if (p < 10) begin
                        acc |= VW'(b) << (8 * (p - 8));
                        if (p == 9) begin
                            emit(gcbp_pkg::FcHeight, acc, gcbp_pkg::ErrNone);
                            if (acc < min_h) fail(gcbp_pkg::ErrHeight);
                            acc = '0;
                        end
                    end else if (p == 10) begin
                        gct_on = b[7];
                        gct_n = 1 << (b[2:0] + 1);
                        emit(gcbp_pkg::FcGctFlag, VW'(b[7]), gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcColorRes, VW'(b[6:4]) + 24'd1, gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcSortFlag, VW'(b[3]), gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcGctEntries, VW'(gct_n), gcbp_pkg::ErrNone);
                    end else if (p == 11) begin
                        emit(gcbp_pkg::FcBgIndex, VW'(b), gcbp_pkg::ErrNone);
                    end else begin
                        emit(gcbp_pkg::FcAspect, VW'(b), gcbp_pkg::ErrNone);
                        enter(gct_on ? PhGlobalTable : PhBlock);
                    end
                end
                PhGlobalTable, PhLocalTable: begin
                    glob = (phase == PhGlobalTable);
                    total = 3 * (glob ? gct_n : lct_n);
                    acc = {acc[15:0], b};
                    if (p % 3 == 2) begin
                        emit(glob ? gcbp_pkg::FcGctColor : gcbp_pkg::FcLctColor, acc,
                             gcbp_pkg::ErrNone);
                        acc = '0;
                    end
                    if (p + 1 >= total) enter(glob ? PhBlock : PhLzwSize);
                end
                PhBlock: begin
                    if (b == gcbp_pkg::ImageSep) begin
                        if (has_img) bump_frame();
                        has_img = 1;
                        enter(PhImage);
                    end else if (b == gcbp_pkg::ExtIntro) begin
                        enter(PhLabel);
                    end else if (b == gcbp_pkg::TrailerB) begin
                        trailer = 1;
                        emit(gcbp_pkg::FcTrailer, '0, gcbp_pkg::ErrNone);
                        pos = '0;
                    end else if (b == gcbp_pkg::NullByte) begin
                        pos = '0;
                    end else begin
                        fail(gcbp_pkg::ErrBlockType);
                    end
                end
                PhLabel: begin
                    if (b == gcbp_pkg::GceLabel) begin
                        if (has_ctl) bump_frame();
                        has_ctl = 1;
                        enter(PhControl);
                    end else if (b == gcbp_pkg::AppLabel) enter(PhAppExt);
                    else if (b == gcbp_pkg::CommentLbl) fail(gcbp_pkg::ErrComment);
                    else if (b == gcbp_pkg::PlainLabel) fail(gcbp_pkg::ErrPlainText);
                    else fail(gcbp_pkg::ErrExtLabel);
                end
                PhControl: begin
                    if (p == 0) emit(gcbp_pkg::FcGceSize, VW'(b), gcbp_pkg::ErrNone);
                    else if (p == 1) begin
                        emit(gcbp_pkg::FcGceRsvd, VW'(b[7:5]), gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcDisposal, VW'(b[4:2]), gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcUserInput, VW'(b[1]), gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcTranspFlag, VW'(b[0]), gcbp_pkg::ErrNone);
                    end else if (p < 4) begin
                        acc |= VW'(b) << (8 * (p - 2));
                        if (p == 3) begin
                            emit(gcbp_pkg::FcDelay, acc, gcbp_pkg::ErrNone);
                            acc = '0;
                        end
                    end else if (p == 4) emit(gcbp_pkg::FcTranspIdx, VW'(b), gcbp_pkg::ErrNone);
                    else if (b != gcbp_pkg::NullByte) fail(gcbp_pkg::ErrGceTerm);
                    else enter(PhBlock);
                end
                PhAppExt: begin
                    if (p < 12) begin
                        // Block size, identifier and authentication bytes are skipped.
                    end else if (p == 12) begin
                        if (b != gcbp_pkg::AppSubSize) fail(gcbp_pkg::ErrAppSize);
                    end else if (p == 13) emit(gcbp_pkg::FcAppByte, VW'(b), gcbp_pkg::ErrNone);
                    else if (p < 16) begin
                        acc |= VW'(b) << (8 * (p - 14));
                        if (p == 15) begin
                            emit(gcbp_pkg::FcAppWord, acc, gcbp_pkg::ErrNone);
                            acc = '0;
                        end
                    end else if (b != gcbp_pkg::NullByte) fail(gcbp_pkg::ErrAppTerm);
                    else enter(PhBlock);
                end
                PhImage: begin
                    if (p < 8) begin
                        acc |= VW'(b) << (8 * p[0]);
                        if (p[0]) begin
                            emit(gcbp_pkg::FcImgLeft + gcbp_pkg::CodeW'(p >> 1), acc,
                                 gcbp_pkg::ErrNone);
                            acc = '0;
                        end
                    end else begin
                        lct_on = b[7];
                        lct_n = 2 << b[2:0];
                        emit(gcbp_pkg::FcLctFlag, VW'(b[7]), gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcInterlace, VW'(b[6]), gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcImgSort, VW'(b[5]), gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcImgRsvd, VW'(b[4:3]), gcbp_pkg::ErrNone);
                        emit(gcbp_pkg::FcLctEntries, VW'(lct_n), gcbp_pkg::ErrNone);
                        enter(lct_on ? PhLocalTable : PhLzwSize);
                    end
                end
                PhLzwSize: begin
                    emit(gcbp_pkg::FcLzwSize, VW'(b), gcbp_pkg::ErrNone);
                    enter(PhSubLen);
                end
                PhSubLen: begin
                    if (b == gcbp_pkg::NullByte) enter(PhBlock);
                    else begin
                        sub_left = b;
                        enter(PhSubData);
                    end
                end
                PhSubData: begin
                    sub_left--;
                    if (sub_left == 0) enter(PhSubLen);
                end
                default: ;
            endcase
        endfunction

        function void note_input(logic [7:0] b, logic fin);
            batch.delete();
            if (phase == PhFailed || phase == PhDone) return;
            take(b);
            if (fin && phase != PhFailed) begin
                if (phase == PhBlock) begin
                    if (trailer) begin
                        emit(gcbp_pkg::FcCleanEnd, '0, gcbp_pkg::ErrNone);
                        phase = PhDone;
                    end else fail(gcbp_pkg::ErrNoTrailer);
                end else fail(gcbp_pkg::ErrTruncated);
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1;
            foreach (batch[i]) pending.push_back(batch[i]);
        endfunction

        function void check_result(logic [55:0] data, logic last);
            field_item_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result item %h last=%b", $time, data, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[5:0] != e.code || data[29:6] != e.value || data[45:30] != e.frame
                || data[49:46] != e.kind || data[55:50] != '0 || last != e.last) begin
                $display("%0t: mismatch expected code=%0d value=%h frame=%0d kind=%0d last=%b",
                         $time, e.code, e.value, e.frame, e.kind, e.last);
                $display("%0t:          actual   code=%0d value=%h frame=%0d kind=%0d last=%b",
                         $time, data[5:0], data[29:6], data[45:30], data[49:46], last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0, s_tlast = 0, m_tready = 0, cfg_valid = 0;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tready, m_tvalid, m_tlast, cfg_ready;
    logic [55:0] m_tdata;

    gif_field_scoreboard fields = new();
    int  bytes_sent = 0;
    int  quiet_cycles = 0;
    bit  calm = 0;
    bit  drained = 0;

    gif_container_byte_parser dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Result side: random stall bursts, checks every accepted item.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) fields.check_result(m_tdata, m_tlast);
            if (stall > 0) begin
                stall--;
                m_tready <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 3) - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("gif_container_byte_parser test failed");
            $finish;
        end
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin = 0);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        fields.note_input(b, fin);
        bytes_sent++;
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        fields.set_reg(idx, data);
    endtask

    task automatic drain_results();
        while (fields.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_color_table(input int entries);
        repeat (3 * entries) send_byte(rnd_byte());
    endtask

    task automatic send_control(input bit bad_term);
        logic [7:0] term;
        term = bad_term ? 8'($urandom_range(1, 255)) : gcbp_pkg::NullByte;
        send_byte(gcbp_pkg::ExtIntro);
        send_byte(gcbp_pkg::GceLabel);
        send_byte(8'h04);
        repeat (4) send_byte(rnd_byte());
        send_byte(term);
    endtask

    task automatic send_app(input bit bad_size, input bit bad_term);
        logic [7:0] sz;
        logic [7:0] term;
        sz = bad_size ? (gcbp_pkg::AppSubSize ^ 8'($urandom_range(1, 255)))
                      : gcbp_pkg::AppSubSize;
        term = bad_term ? 8'($urandom_range(1, 255)) : gcbp_pkg::NullByte;
        send_byte(gcbp_pkg::ExtIntro);
        send_byte(gcbp_pkg::AppLabel);
        send_byte(8'h0b);
        repeat (11) send_byte(rnd_byte());
        send_byte(sz);
        repeat (3) send_byte(rnd_byte());
        send_byte(term);
    endtask

    // Table sizes stay small so that the file stays near its byte budget.
    function automatic logic [2:0] table_size();
        return 3'($urandom_range(0, 2));
    endfunction

    task automatic send_image(input bit force_lct);
        logic [7:0] packed_b;
        packed_b = rnd_byte() & 8'hf8;
        packed_b[2:0] = table_size();
        if (force_lct) packed_b[7] = 1;
        send_byte(gcbp_pkg::ImageSep);
        repeat (8) send_byte(rnd_byte());
        send_byte(packed_b);
        if (packed_b[7]) send_color_table(2 << packed_b[2:0]);
        send_byte(rnd_byte());
        repeat ($urandom_range(0, 2))
        begin
            int len;
            // A long sub-block only while the budget still has room for it.
            len = ($urandom_range(0, 9) == 0 && bytes_sent + 300 < ByteBudget)
                  ? $urandom_range(200, 255) : $urandom_range(1, 6);
            send_byte(8'(len));
            repeat (len) send_byte(rnd_byte());
        end
        send_byte(gcbp_pkg::NullByte);
    endtask

    initial
    begin
        int          head_mode;
        int          end_mode;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  screen;
        logic [7:0]  sig_fix;

        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        head_mode = $urandom_range(0, 11);
        w = 16'($urandom_range(0, 65535));
        h = 16'($urandom_range(0, 65535));
        if (head_mode == 1 && w == 16'hffff) w = 16'hfffe;
        if (head_mode == 2 && h == 16'hffff) h = 16'hfffe;
        write_reg(gcbp_pkg::RegMinWidth,
                  (head_mode == 1) ? w + 16'd1 : 16'($urandom_range(0, w)));
        write_reg(gcbp_pkg::RegMinHeight, (head_mode == 2) ? h + 16'd1 : h);
        write_reg(RegUnused, 16'($urandom_range(0, 65535)));
        cfg_valid <= 0;

        // Header, optionally with a corrupted signature byte.
        sig_fix = (head_mode == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
        send_byte(8'h47);
        send_byte(8'h49 ^ sig_fix);
        send_byte(8'h46);
        repeat (3) send_byte(rnd_byte());
        send_byte(w[7:0]); send_byte(w[15:8]);
        send_byte(h[7:0]); send_byte(h[15:8]);
        screen = rnd_byte();
        screen[2:0] = table_size();
        send_byte(screen);
        send_byte(rnd_byte());
        send_byte(rnd_byte());
        if (screen[7]) send_color_table(1 << (screen[2:0] + 1));

        send_control(0);
        send_app(0, 0);
        send_image(1);
        send_byte(gcbp_pkg::NullByte);

        while (bytes_sent < ByteBudget)
        begin
            if (bytes_sent > ByteBudget / 2 && !drained) begin
                // Idle point: all results in, then the limits go to their extremes.
                drained = 1;
                s_tvalid <= 0;
                drain_results();
                write_reg(gcbp_pkg::RegMinWidth, 16'hffff);
                write_reg(gcbp_pkg::RegMinHeight, 16'h0000);
                cfg_valid <= 0;
            end
            if (bytes_sent > ByteBudget * 4 / 5) calm = 1;
            case ($urandom_range(0, 9))
                0, 1, 2: send_control(0);
                3, 4:    send_app(0, 0);
                5, 6, 7: send_image(0);
                8:       send_byte(gcbp_pkg::TrailerB);
                default: send_byte(gcbp_pkg::NullByte);
            endcase
        end

        end_mode = $urandom_range(0, 8);
        case (end_mode)
            0: send_byte(gcbp_pkg::TrailerB, 1);
            1: send_byte(gcbp_pkg::NullByte, 1);
            2: begin send_byte(gcbp_pkg::ExtIntro); send_byte(gcbp_pkg::GceLabel, 1); end
            3: send_byte(($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7f);
            4: begin
                send_byte(gcbp_pkg::ExtIntro);
                case ($urandom_range(0, 2))
                    0:       send_byte(gcbp_pkg::CommentLbl);
                    1:       send_byte(gcbp_pkg::PlainLabel);
                    default: send_byte(8'h55);
                endcase
            end
            5: send_app(1, 0);
            6: send_control(1);
            7: send_app(0, 1);
            default: send_image(0);
        endcase
        // Two more bytes follow; the parser ignores them once it has stopped, and the last carries tlast.
        send_byte(rnd_byte());
        send_byte(rnd_byte(), 1);
        s_tvalid <= 0;
        s_tlast  <= 0;

        while (fields.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fields.errors == 0 && fields.pending.size() == 0)
            $display("gif_container_byte_parser test passed");
        else
            $display("gif_container_byte_parser test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/gcbp_pkg.sv
rtl/core/gif_container_byte_parser.sv
tb/gif_container_byte_parser_tb.sv
